// File: rtl/core/plk_pkg.sv
// ----------------------------------------------------------------------------
// PIN lock package
// Shared types and constants for the keypad PIN lock controller.
// ----------------------------------------------------------------------------
package plk_pkg;

  // Keys held per PIN entry
  localparam int PinLength = 4;
  // Entry counter must hold PinLength itself
  localparam int CntW = $clog2(PinLength + 1);
  // Index into the entry buffer and stored PIN
  localparam int IdxW = (PinLength > 1) ? $clog2(PinLength) : 1;

  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;

  localparam logic [3:0] FAIL_SAT = 4'hF;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_FAILURES  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_LOCKOUT_TICKS = 1'b1;

  localparam logic [3:0] MAX_FAILURES_RST  = 4'd3;
  localparam logic [7:0] LOCKOUT_TICKS_RST = 8'd10;

  typedef enum logic [1:0] {
    MODE_OPEN    = 2'd0,
    MODE_SETUP   = 2'd1,
    MODE_LOCKED  = 2'd2,
    MODE_LOCKOUT = 2'd3
  } plk_mode_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_KEY        = 3'd1,
    EV_SET        = 3'd2,
    EV_GRANTED    = 3'd3,
    EV_DENIED     = 3'd4,
    EV_LOCK_BEGIN = 3'd5,
    EV_LOCK_OVER  = 3'd6
  } plk_event_t;

  typedef struct packed {
    logic [3:0] max_failures;
    logic [7:0] lockout_ticks;
  } plk_cfg_t;

  typedef struct packed {
    plk_mode_t  mode;
    logic [2:0] entered_count;
    logic [3:0] tries_left;
    plk_event_t event_res;
    logic       bolt_closed;
    logic [7:0] lockout_left;
  } plk_result_t;

endpackage

// File: rtl/core/plk_if.sv
// ----------------------------------------------------------------------------
// PIN lock channel interfaces
// Valid/ready channels for key/tick items and for result items.
// ----------------------------------------------------------------------------
interface plk_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [3:0] key_code;

  modport source (output valid, output action, output key_code, input ready);
  modport sink   (input valid, input action, input key_code, output ready);
endinterface

interface plk_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] entered_count;
  logic [3:0] tries_left;
  logic [2:0] event_res;
  logic       bolt_closed;
  logic [7:0] lockout_left;

  modport source (output valid, output mode, output entered_count, output tries_left,
                  output event_res, output bolt_closed, output lockout_left, input ready);
  modport sink   (input valid, input mode, input entered_count, input tries_left,
                  input event_res, input bolt_closed, input lockout_left, output ready);
endinterface

// File: rtl/core/pin_lock_controller.sv
// ----------------------------------------------------------------------------
// Keypad PIN lock controller
// Open / setup / locked / lockout modes driven by key presses and ticks.
// ----------------------------------------------------------------------------
// Each input item is a decoded key press or a one-second tick, and every item
// gives exactly one result item: the mode after the item, keys in the entry
// buffer, tries left, an event code, the bolt position and the ticks left in
// lockout. The block takes one item per clock cycle while the output accepts
// results. An item is latched in the input register, processed in one pass
// through the engine, which updates the lock state, and lands in the result
// register. The result register decouples the two sides, so a new item is
// taken while an earlier result waits on the output. Write the max_failures
// (index 0) and lockout_ticks (index 1) registers only while no item is in
// flight; a lockout already running keeps its count.
module pin_lock_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  plk_in_if.sink                       in_ch,
  plk_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [plk_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [7:0]                   cfg_data
);
  import plk_pkg::*;

  plk_cfg_t    cfg_r;
  logic        in_valid_r;
  logic        act_r;
  logic [3:0]  key_r;
  logic        out_valid_r;
  plk_result_t out_r;
  plk_result_t res;
  logic        in_take;
  logic        advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_failures  <= MAX_FAILURES_RST;
      cfg_r.lockout_ticks <= LOCKOUT_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_FAILURES:  cfg_r.max_failures  <= cfg_data[3:0];
        CFG_LOCKOUT_TICKS: cfg_r.lockout_ticks <= cfg_data;
      endcase
    end
  end

  // Move the held item into the engine whenever the result slot frees up
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // Hold the item payload until it is processed
  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r <= in_ch.action;
      key_r <= in_ch.key_code;
    end
  end

  plk_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .action   (act_r),
    .key_code (key_r),
    .cfg      (cfg_r),
    .res      (res)
  );

  // Result register: fill on advance, drop once the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_r <= res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mode          = out_r.mode;
  assign out_ch.entered_count = out_r.entered_count;
  assign out_ch.tries_left    = out_r.tries_left;
  assign out_ch.event_res     = out_r.event_res;
  assign out_ch.bolt_closed   = out_r.bolt_closed;
  assign out_ch.lockout_left  = out_r.lockout_left;

`ifndef ASSERT_OFF
  // An accepted item is held until the engine consumes it
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r)
    else $error("held item lost before processing");

  // An accepted item always shows up in the input register next cycle
  a_item_taken: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_valid_r)
    else $error("accepted item not registered");

  // Lockout ticks are reported only in lockout
  a_lockout_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.mode != MODE_LOCKOUT) |-> (out_r.lockout_left == 8'd0))
    else $error("lockout_left nonzero outside lockout");

  // A granted entry always opens the lock
  a_granted_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.event_res == EV_GRANTED) |->
      (out_r.mode == MODE_OPEN) && !out_r.bolt_closed)
    else $error("granted without opening");
`endif

endmodule

// File: rtl/core/plk_engine.sv
// ----------------------------------------------------------------------------
// PIN lock engine
// Lock state, entry buffer and stored PIN; one item processed per step.
// ----------------------------------------------------------------------------
module plk_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                action,
  input  logic [3:0]          key_code,
  input  plk_pkg::plk_cfg_t    cfg,
  output plk_pkg::plk_result_t res
);
  import plk_pkg::*;

  plk_mode_t        mode_r, mode_nxt;
  logic [3:0]       stored_pin_r [PinLength];
  logic [3:0]       entry_r      [PinLength];
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [3:0]       fail_r, fail_nxt;
  logic [7:0]       lock_r, lock_nxt;

  logic             entry_full;
  logic             last_key;
  logic [IdxW-1:0]  wr_idx;
  logic             is_key;
  logic             push;
  logic             commit;
  logic             match;
  logic [3:0]       fail_inc;
  plk_event_t       ev;
  logic [CntW+2:0]  cnt_ext;

  assign entry_full = (cnt_r >= CntW'(PinLength));
  assign last_key   = (cnt_r == CntW'(PinLength - 1));
  assign wr_idx     = cnt_r[IdxW-1:0];
  assign is_key     = (key_code != KEY_STAR) && (key_code != KEY_HASH);
  assign fail_inc   = (fail_r != FAIL_SAT) ? fail_r + 4'd1 : fail_r;

  // Compare stored PIN against the buffer with the incoming key in place
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PinLength; i++) begin
      if (!entry_full && (IdxW'(i) == wr_idx)) begin
        if (key_code != stored_pin_r[i]) match = 1'b0;
      end else begin
        if (entry_r[i] != stored_pin_r[i]) match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    fail_nxt = fail_r;
    lock_nxt = lock_r;
    ev       = EV_NONE;
    push     = 1'b0;
    commit   = 1'b0;
    if (action) begin
      if (mode_r == MODE_LOCKOUT) begin
        if (lock_r <= 8'd1) begin
          lock_nxt = 8'd0;
          fail_nxt = 4'd0;
          cnt_nxt  = '0;
          mode_nxt = MODE_LOCKED;
          ev       = EV_LOCK_OVER;
        end else begin
          lock_nxt = lock_r - 8'd1;
        end
      end
    end else begin
      unique case (mode_r)
        MODE_OPEN: begin
          if (key_code == KEY_STAR) begin
            cnt_nxt  = '0;
            mode_nxt = MODE_SETUP;
            ev       = EV_KEY;
          end
        end
        MODE_SETUP: begin
          if (key_code == KEY_STAR) begin
            if (entry_full) begin
              commit   = 1'b1;
              cnt_nxt  = '0;
              fail_nxt = 4'd0;
              mode_nxt = MODE_LOCKED;
              ev       = EV_SET;
            end
          end else if (key_code != KEY_HASH && !entry_full) begin
            push    = 1'b1;
            cnt_nxt = cnt_r + CntW'(1);
            ev      = EV_KEY;
          end
        end
        MODE_LOCKED: begin
          if (is_key) begin
            push = !entry_full;
            ev   = EV_KEY;
            if (entry_full || last_key) begin
              cnt_nxt = '0;
              if (match) begin
                fail_nxt = 4'd0;
                mode_nxt = MODE_OPEN;
                ev       = EV_GRANTED;
              end else begin
                fail_nxt = fail_inc;
                if (fail_inc >= cfg.max_failures) begin
                  mode_nxt = MODE_LOCKOUT;
                  lock_nxt = cfg.lockout_ticks;
                  ev       = EV_LOCK_BEGIN;
                end else begin
                  ev = EV_DENIED;
                end
              end
            end else begin
              cnt_nxt = cnt_r + CntW'(1);
            end
          end
        end
        MODE_LOCKOUT: begin
          // keys are dropped during lockout
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OPEN;
      cnt_r  <= '0;
      fail_r <= 4'd0;
      lock_r <= 8'd0;
      for (int i = 0; i < PinLength; i++) stored_pin_r[i] <= 4'd0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      fail_r <= fail_nxt;
      lock_r <= lock_nxt;
      if (commit) begin
        for (int i = 0; i < PinLength; i++) stored_pin_r[i] <= entry_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && push) entry_r[wr_idx] <= key_code;
  end

  assign cnt_ext = (CntW + 3)'(cnt_nxt);

  always_comb begin
    res.mode          = mode_nxt;
    res.entered_count = cnt_ext[2:0];
    res.tries_left    = (cfg.max_failures > fail_nxt) ? cfg.max_failures - fail_nxt : 4'd0;
    res.event_res     = ev;
    res.bolt_closed   = (mode_nxt == MODE_LOCKED) || (mode_nxt == MODE_LOCKOUT);
    res.lockout_left  = (mode_nxt == MODE_LOCKOUT) ? lock_nxt : 8'd0;
  end

endmodule
